/* hw/rtl/pnr_pkg.sv */
// shared types and constants for the polynomial newton root block
package pnr_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd2;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_ZERO_DERIV = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic signed [63:0] W_MAX = 64'sd2147483647;
    localparam logic signed [63:0] W_MIN = -64'sd2147483648;

    // divider request and response
    typedef struct packed {
        logic start;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
        logic signed [31:0] quo;
    } div_rsp_t;

endpackage

/* hw/rtl/polynomial_newton_root_top.sv */
// top level of the newton-raphson polynomial root finder
//
// usage: write poly_degree, tolerance and coef_0..coef_5 through the cfg port
// while idle (cfg_index is the register place, cfg_data the value).
// a start guess arrives as one transfer on the s_axis group (tdata = start_x).
// the result leaves as one transfer on the m_axis group:
// tdata = root_x, iteration_count, padding; tuser = status.
// each iteration evaluates p(x) by horner (one multiply-add per cycle on the
// shared multiplier), then p'(x) by horner through the deval and step states,
// then a serial divide for h = p*2^frac / p'. an item takes up to
// MAX_ITERATIONS iterations, each ending in a new x = x - h or in a result.
// s_axis_tready is high only while idle; the block works on one item at a time.
// a finished result moves to an output register that holds it while
// m_axis_tready is low; the next item may run meanwhile, but its result
// waits in the final state until the output register is free.
// reset clears control state and loads the register defaults:
// degree 1, tolerance 1, coef_1 = 1.0, other coefficients zero.
module polynomial_newton_root_top
#(
    parameter int MAX_DEGREE = 5,
    parameter int MAX_ITERATIONS = 64,
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // start_x
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [39:0] m_axis_tdata,   // root_x, iteration_count, zero pad
    output logic [1:0] m_axis_tuser     // status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PEVAL = 3'd1;
    localparam logic [2:0] S_DEVAL = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_STEP = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    // configuration registers
    logic [2:0] deg_reg;
    logic [30:0] tol_reg;
    logic signed [31:0] coef_reg [0:5];

    logic [2:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [6:0] cnt_reg, cnt_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] p_reg, p_next;
    logic ovf_reg, ovf_next;
    logic [1:0] st_reg, st_next;
    logic [2:0] deg_eff;
    logic [2:0] kc_idx;
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    logic signed [63:0] sum;
    logic signed [63:0] kc;
    logic signed [63:0] diff;
    logic signed [31:0] mag;
    logic out_valid_reg;
    logic [39:0] out_data_reg;
    logic [1:0] out_user_reg;
    logic out_load;
    pnr_pkg::div_req_t dreq;
    pnr_pkg::div_rsp_t drsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg <= 3'd1;
            tol_reg <= 31'd1;
            coef_reg[0] <= '0;
            coef_reg[1] <= 32'sd65536;
            coef_reg[2] <= '0;
            coef_reg[3] <= '0;
            coef_reg[4] <= '0;
            coef_reg[5] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pnr_pkg::REG_DEGREE)
                deg_reg <= cfg_data[2:0];
            else if (cfg_index == pnr_pkg::REG_TOL)
                tol_reg <= cfg_data[30:0];
            else
                coef_reg[cfg_index - pnr_pkg::REG_COEF0] <= cfg_data;
        end
    end

    assign deg_eff = (32'(deg_reg) > MAX_DEGREE) ? 3'(MAX_DEGREE) : deg_reg;

    // derivative coefficients k*coef_k, small constant multiplier
    // the first derivative term uses the top power while p(x) finishes
    assign kc_idx = (state_reg == S_PEVAL) ? deg_eff : k_reg;
    assign kc = $signed({61'd0, kc_idx}) * 64'(coef_reg[kc_idx]);

    // shared multiplier with rounding to nearest, ties up
    assign prod = 64'(acc_reg) * 64'(x_reg);
    assign rnd = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    // final state hands the result over once the output register is free
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        cnt_next = cnt_reg;
        x_next = x_reg;
        acc_next = acc_reg;
        p_next = p_reg;
        ovf_next = ovf_reg;
        st_next = st_reg;
        dreq = '0;
        sum = '0;
        diff = 64'(x_reg) - 64'(drsp.quo);
        mag = drsp.quo[31] ? -drsp.quo : drsp.quo;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    x_next = s_axis_tdata;
                    cnt_next = 7'd1;
                    acc_next = coef_reg[deg_eff];
                    k_next = deg_eff;
                    ovf_next = 1'b0;
                    state_next = S_PEVAL;
                end
            end
            S_PEVAL:
            begin
                if (k_reg == 3'd0)
                begin
                    p_next = acc_reg;
                    k_next = deg_eff;
                    if (deg_eff == 3'd0)
                    begin
                        acc_next = '0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        sum = kc;
                        if (sum > pnr_pkg::W_MAX || sum < pnr_pkg::W_MIN)
                            ovf_next = 1'b1;
                        acc_next = sum[31:0];
                        state_next = S_DEVAL;
                    end
                end
                else
                begin
                    sum = rnd + 64'(coef_reg[k_reg - 3'd1]);
                    if (sum > pnr_pkg::W_MAX)
                    begin
                        ovf_next = 1'b1;
                        acc_next = 32'sh7fffffff;
                    end
                    else if (sum < pnr_pkg::W_MIN)
                    begin
                        ovf_next = 1'b1;
                        acc_next = 32'sh80000000;
                    end
                    else
                        acc_next = sum[31:0];
                    k_next = k_reg - 3'd1;
                end
            end
            S_DEVAL:
            begin
                // k_reg walks down; the sum uses (k-1)*coef_{k-1}
                if (k_reg <= 3'd1)
                    state_next = S_CHECK;
                else
                begin
                    k_next = k_reg - 3'd1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // k_reg already decremented: add k*coef_k
                sum = rnd + kc;
                if (sum > pnr_pkg::W_MAX)
                begin
                    ovf_next = 1'b1;
                    acc_next = 32'sh7fffffff;
                end
                else if (sum < pnr_pkg::W_MIN)
                begin
                    ovf_next = 1'b1;
                    acc_next = 32'sh80000000;
                end
                else
                    acc_next = sum[31:0];
                state_next = S_DEVAL;
            end
            S_CHECK:
            begin
                if (ovf_reg)
                begin
                    st_next = pnr_pkg::ST_OVERFLOW;
                    state_next = S_OUT;
                end
                else if (acc_reg == '0)
                begin
                    st_next = pnr_pkg::ST_ZERO_DERIV;
                    state_next = S_OUT;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num = 64'(p_reg) <<< FRAC_BITS;
                    dreq.den = acc_reg;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    if (drsp.ovf)
                    begin
                        st_next = pnr_pkg::ST_OVERFLOW;
                        state_next = S_OUT;
                    end
                    else if ({1'b0, mag} <= {2'b0, tol_reg})
                    begin
                        st_next = pnr_pkg::ST_CONVERGED;
                        state_next = S_OUT;
                    end
                    else if (diff > pnr_pkg::W_MAX)
                    begin
                        x_next = 32'sh7fffffff;
                        st_next = pnr_pkg::ST_OVERFLOW;
                        state_next = S_OUT;
                    end
                    else if (diff < pnr_pkg::W_MIN)
                    begin
                        x_next = 32'sh80000000;
                        st_next = pnr_pkg::ST_OVERFLOW;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        x_next = diff[31:0];
                        if (32'(cnt_reg) >= MAX_ITERATIONS)
                        begin
                            st_next = pnr_pkg::ST_LIMIT;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 7'd1;
                            acc_next = coef_reg[deg_eff];
                            k_next = deg_eff;
                            ovf_next = 1'b0;
                            state_next = S_PEVAL;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    pnr_div u_div
    (
        .clk(clk),
        .rst_n(rst_n),
        .req(dreq),
        .rsp(drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        cnt_reg <= cnt_next;
        x_reg <= x_next;
        acc_reg <= acc_next;
        p_reg <= p_next;
        ovf_reg <= ovf_next;
        st_reg <= st_next;
    end

    // output register, holds the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_user_reg <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg <= {1'b0, cnt_reg, x_reg};
            out_user_reg <= st_reg;
        end
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

`ifndef SYNTHESIS
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[38:32] != 7'd0)) else $error("zero count");
`endif

endmodule

/* hw/rtl/pnr_div.sv */
// serial signed divider, one quotient bit per cycle, truncation toward zero
module pnr_div
(
    input  logic clk,
    input  logic rst_n,
    input  pnr_pkg::div_req_t req,
    output pnr_pkg::div_rsp_t rsp
);

    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic neg_reg, neg_next;
    logic done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] shifted;
    logic [63:0] sq;
    logic sovf;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        shifted = {rem_reg[62:0], quo_reg[63]};
        trial = {1'b0, shifted} - {33'd0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = 7'd0;
            rem_next = 64'd0;
            quo_next = req.num[63] ? 64'(-req.num) : 64'(req.num);
            den_next = req.den[31] ? 32'(-req.den) : 32'(req.den);
            neg_next = req.num[63] ^ req.den[31];
        end
        else if (busy_reg)
        begin
            if (!trial[64])
                rem_next = trial[63:0];
            else
                rem_next = shifted;
            quo_next = {quo_reg[62:0], ~trial[64]};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // magnitude quotient fits 2^63 at most; sign applied then range checked
    always_comb
    begin
        sq = neg_reg ? 64'(-quo_reg) : quo_reg;
        sovf = ($signed(sq) > pnr_pkg::W_MAX) || ($signed(sq) < pnr_pkg::W_MIN);
        rsp.done = done_reg;
        rsp.ovf = sovf;
        rsp.quo = sq[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

endmodule
